// File: design/calendar_date_serial_converter_defines.svh
// Assertion macros for the calendar date serial converter.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef CALENDAR_DATE_SERIAL_CONVERTER_DEFINES_SVH
`define CALENDAR_DATE_SERIAL_CONVERTER_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define CDSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cdsc assertion failed");

// Check that a cause is followed by an effect at the next clock edge.
`define CDSC_ASSERT_NEXT(lbl, cause, effect) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |=> (effect)) \
    else $error("cdsc assertion failed");

`endif

// File: design/cdsc_pkg.sv
// Package of the calendar date serial converter: types, calendar constants
// and small table functions. Depends on nothing.
`timescale 1ns / 1ps

package cdsc_pkg;

  localparam int unsigned NSTG = 8;

  localparam logic [13:0] MAX_YEAR   = 14'd9999;
  localparam logic [21:0] MAX_COUNT  = 22'd3652058;
  localparam logic [21:0] DAYS_400Y  = 22'd146097;
  localparam logic [17:0] DAYS_100Y  = 18'd36524;
  localparam logic [17:0] DAYS_4Y    = 18'd1461;
  localparam logic [10:0] DAYS_1Y    = 11'd365;

  // Reciprocals, rounded down (RCP_100 up): an estimate is at most one too small.
  localparam logic [14:0] RCP_400Y = 15'd29397;  // 2^32 / 146097, rounded down, less one
  localparam logic [15:0] RCP_4Y   = 16'd45933;  // 2^26 / 1461
  localparam logic [12:0] RCP_100  = 13'd5243;   // 2^19 / 100, exact below 43699
  localparam logic [9:0]  RCP_7    = 10'd585;    // 2^12 / 7

  typedef enum logic {
    CMD_TO_SERIAL = 1'b0,
    CMD_TO_DATE   = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic        bad;
    logic        leap;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [21:0] cnt;     // serial day count
    logic [21:0] jan1;    // serial count of 1 January
    logic [7:0]  hund;    // year / 100
    logic [7:0]  hundp;   // (year - 1) / 100
    logic [17:0] r;       // running remainder
    logic [4:0]  n400;
    logic [1:0]  n100;
    logic [4:0]  n4;
    logic [8:0]  doy;
    logic [2:0]  wd;
    logic [2:0]  j7;
    logic [5:0]  week;
  } stage_t;

  // Day of year of the first of month m in a common year.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] l;
    case (m)
      4'd2:                      l = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   l = 5'd30;
      default:                   l = 5'd31;
    endcase
    return l;
  endfunction

  // Residue mod 7: octal digits sum to the same residue since 8 = 1 mod 7.
  function automatic logic [2:0] mod7(input logic [21:0] x);
    logic [23:0] w;
    logic [5:0]  s;
    logic [3:0]  t;
    w = {2'b00, x};
    s = 6'(w[2:0]) + 6'(w[5:3]) + 6'(w[8:6]) + 6'(w[11:9])
      + 6'(w[14:12]) + 6'(w[17:15]) + 6'(w[20:18]) + 6'(w[23:21]);
    t = 4'(s[5:3]) + 4'(s[2:0]);
    if (t >= 4'd7) t = t - 4'd7;
    if (t >= 4'd7) t = t - 4'd7;
    return t[2:0];
  endfunction

endpackage

// File: design/calendar_date_serial_converter.sv
// Top level of the calendar date serial converter: an eight-stage pipeline.
// Depends on cdsc_pkg and calendar_date_serial_converter_defines.svh.
//
//   channel  handshake               payload
//   in       in_valid_i/in_ready_o   cmd_i, day_i, month_i, year_i, day_count_i
//   out      out_valid_o/out_ready_i serial_days_o, out_day_o, out_month_o,
//                                    out_year_o, weekday_o, week_of_year_o,
//                                    invalid_o
//
// One transfer in per cycle while in_ready_o is high; a result passes through
// stage registers 0 to 7 and leaves from the last one. Stage count is set by the
// chain of constant divisions (400, 100 and 4 year cycles, then months).
// Each stage holds its item while the next one is full and stalled, and an
// empty stage loads anyway, so bubbles close up. Reset empties all stages.
`timescale 1ns / 1ps
`include "calendar_date_serial_converter_defines.svh"

module calendar_date_serial_converter
  import cdsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [4:0]  day_i,
  input  logic [3:0]  month_i,
  input  logic [13:0] year_i,
  input  logic [21:0] day_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [21:0] serial_days_o,
  output logic [4:0]  out_day_o,
  output logic [3:0]  out_month_o,
  output logic [13:0] out_year_o,
  output logic [2:0]  weekday_o,
  output logic [5:0]  week_of_year_o,
  output logic        invalid_o
);

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] rdy;
  stage_t          stg_q [NSTG];
  stage_t          stg_d [NSTG];

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  // Stage 0: capture the transfer, start the divisions by reciprocals.
  always_comb begin
    stage_t      s;
    logic [36:0] p400;
    logic [26:0] py;
    logic [26:0] pp;
    logic [13:0] ym1;
    s = '0;
    s.cmd   = cmd_e'(cmd_i);
    s.day   = day_i;
    s.month = month_i;
    s.year  = year_i;
    s.cnt   = day_count_i;
    s.bad   = (cmd_e'(cmd_i) == CMD_TO_DATE) && (day_count_i > MAX_COUNT);
    p400    = 37'(day_count_i) * 37'(RCP_400Y);
    s.n400  = p400[36:32];
    ym1     = year_i - 14'd1;
    py      = 27'(year_i) * 27'(RCP_100);
    pp      = 27'(ym1) * 27'(RCP_100);
    s.hund  = py[26:19];
    s.hundp = pp[26:19];
    stg_d[0] = s;
  end

  // Stage 1: finish the 400 year split, or check the date and find 1 January.
  always_comb begin
    stage_t      s;
    logic [21:0] rb;
    logic [4:0]  len;
    logic [13:0] p;
    logic [13:0] y100;
    s = stg_q[0];
    rb = '0; len = '0; p = '0; y100 = '0;
    if (s.cmd == CMD_TO_DATE) begin
      rb = s.cnt - 22'(s.n400) * DAYS_400Y;
      if (rb >= DAYS_400Y) begin
        rb     = rb - DAYS_400Y;
        s.n400 = s.n400 + 5'd1;
      end
      s.r = rb[17:0];
    end else begin
      y100   = s.year - 14'(s.hund) * 14'd100;
      s.leap = (s.year[1:0] == 2'd0) && ((y100 != 14'd0) || (s.hund[1:0] == 2'd0));
      len    = month_len(s.month) + 5'((s.month == 4'd2) && s.leap);
      s.bad  = (s.year == 14'd0) || (s.year > MAX_YEAR) || (s.month == 4'd0)
             || (s.month > 4'd12) || (s.day == 5'd0) || (s.day > len);
      s.doy  = month_start(s.month) + 9'(s.day) - 9'd1 + 9'((s.month > 4'd2) && s.leap);
      p      = s.year - 14'd1;
      s.jan1 = 22'(p) * 22'(DAYS_1Y) + 22'(p[13:2]) - 22'(s.hundp) + 22'(s.hundp[7:2]);
    end
    stg_d[1] = s;
  end

  // Stage 2: century split, or add the day of year to 1 January.
  always_comb begin
    stage_t s;
    s = stg_q[1];
    if (s.cmd == CMD_TO_DATE) begin
      if (s.r >= 18'd109572) begin
        s.n100 = 2'd3;
        s.r    = s.r - 18'd109572;
      end else if (s.r >= 18'd73048) begin
        s.n100 = 2'd2;
        s.r    = s.r - 18'd73048;
      end else if (s.r >= DAYS_100Y) begin
        s.n100 = 2'd1;
        s.r    = s.r - DAYS_100Y;
      end else begin
        s.n100 = 2'd0;
      end
    end else begin
      s.cnt = s.jan1 + 22'(s.doy);
    end
    stg_d[2] = s;
  end

  // Stage 3: estimate the count of four year cycles.
  always_comb begin
    stage_t      s;
    logic [31:0] p4;
    s  = stg_q[2];
    p4 = 32'(s.r[15:0]) * 32'(RCP_4Y);
    if (s.cmd == CMD_TO_DATE) begin
      s.n4 = p4[30:26];
    end
    stg_d[3] = s;
  end

  // Stage 4: correct the four year estimate.
  always_comb begin
    stage_t s;
    s = stg_q[3];
    if (s.cmd == CMD_TO_DATE) begin
      s.r = s.r - 18'(s.n4) * DAYS_4Y;
      if (s.r >= DAYS_4Y) begin
        s.r  = s.r - DAYS_4Y;
        s.n4 = s.n4 + 5'd1;
      end
    end
    stg_d[4] = s;
  end

  // Stage 5: single years, then build year, leap flag and 1 January.
  always_comb begin
    stage_t     s;
    logic [1:0] n1;
    s  = stg_q[4];
    n1 = '0;
    if (s.cmd == CMD_TO_DATE) begin
      if (s.r >= 18'd1095)      n1 = 2'd3;
      else if (s.r >= 18'd730)  n1 = 2'd2;
      else if (s.r >= 18'd365)  n1 = 2'd1;
      else                      n1 = 2'd0;
      s.doy  = 9'(s.r - 18'(n1) * 18'(DAYS_1Y));
      s.year = 14'(s.n400) * 14'd400 + 14'(s.n100) * 14'd100
             + 14'(s.n4) * 14'd4 + 14'(n1) + 14'd1;
      // Leap when the year ends a four year cycle, but not a plain century.
      s.leap = (n1 == 2'd3) && ((s.n4 != 5'd24) || (s.n100 == 2'd3));
      s.jan1 = s.cnt - 22'(s.doy);
    end
    stg_d[5] = s;
  end

  // Stage 6: month and day from the day of year, weekday residues.
  always_comb begin
    stage_t     s;
    logic [3:0] m;
    logic [8:0] st;
    s  = stg_q[5];
    m  = 4'd1;
    st = '0;
    if (s.cmd == CMD_TO_DATE) begin
      for (int k = 2; k <= 12; k++) begin
        if (s.doy >= month_start(4'(k)) + 9'((k > 2) && s.leap)) m = m + 4'd1;
      end
      st      = month_start(m) + 9'((m > 4'd2) && s.leap);
      s.month = m;
      s.day   = 5'(s.doy - st + 9'd1);
    end
    s.wd = mod7(s.cnt);
    s.j7 = mod7(s.jan1);
    stg_d[6] = s;
  end

  // Stage 7: week of year; zero every field of an invalid result but the invalid flag.
  always_comb begin
    stage_t      s;
    logic [9:0]  x;
    logic [19:0] pw;
    logic [5:0]  q;
    logic [9:0]  rm;
    s  = stg_q[6];
    x  = 10'(s.doy) + 10'(s.j7);
    pw = 20'(x) * 20'(RCP_7);
    q  = pw[17:12];
    rm = x - 10'(q) * 10'd7;
    if (rm >= 10'd7) q = q + 6'd1;
    s.week = q + 6'd1;
    if (s.bad) begin
      s.cnt   = '0;
      s.day   = '0;
      s.month = '0;
      s.year  = '0;
      s.wd    = '0;
      s.week  = '0;
    end
    stg_d[7] = s;
  end

  // Advance valid bits; hold a stage while its successor is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) stg_q[0] <= stg_d[0];
  end

  for (genvar g = 1; g < NSTG; g++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (rdy[g] && vld_q[g-1]) stg_q[g] <= stg_d[g];
    end
  end

  assign out_valid_o    = vld_q[NSTG-1];
  assign serial_days_o  = stg_q[NSTG-1].cnt;
  assign out_day_o      = stg_q[NSTG-1].day;
  assign out_month_o    = stg_q[NSTG-1].month;
  assign out_year_o     = stg_q[NSTG-1].year;
  assign weekday_o      = stg_q[NSTG-1].wd;
  assign week_of_year_o = stg_q[NSTG-1].week;
  assign invalid_o      = stg_q[NSTG-1].bad;

  `CDSC_ASSERT_NEXT(a_enter, in_valid_i && in_ready_o, vld_q[0])
  `CDSC_ASSERT(a_bad_zero, !(out_valid_o && invalid_o) || (serial_days_o == 22'd0 && week_of_year_o == 6'd0 && out_year_o == 14'd0))
  `CDSC_ASSERT(a_good_range, !(out_valid_o && !invalid_o) || (weekday_o < 3'd7 && week_of_year_o >= 6'd1 && week_of_year_o <= 6'd54))
  `CDSC_ASSERT(a_good_date, !(out_valid_o && !invalid_o) || (out_month_o >= 4'd1 && out_month_o <= 4'd12 && out_day_o >= 5'd1))

endmodule

// File: verif/tb_calendar_date_serial_converter.sv
// Testbench for the calendar date serial converter: drives dates and day
// counts under random idling and checks every result. Depends on cdsc_pkg.
`timescale 1ns / 1ps

module tb_calendar_date_serial_converter;
  import cdsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned LAST_COUNT = 3652058;
  localparam int unsigned HOLD_OFF_LEN = 300;

  typedef struct packed {
    logic [21:0] serial_days;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    logic [5:0]  week;
    logic        invalid;
  } date_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = CMD_TO_SERIAL;
  logic [4:0]  day_i = '0;
  logic [3:0]  month_i = '0;
  logic [13:0] year_i = '0;
  logic [21:0] day_count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [21:0] serial_days_o;
  logic [4:0]  out_day_o;
  logic [3:0]  out_month_o;
  logic [13:0] out_year_o;
  logic [2:0]  weekday_o;
  logic [5:0]  week_of_year_o;
  logic        invalid_o;

  date_result_t pending_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  burst_left = 0;
  int unsigned  hold_off_cycles = 0;
  int unsigned  hold_off_reqs = 0;
  int unsigned  hold_off_seen = 0;

  calendar_date_serial_converter uut (.*);

  always #4 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver stalls: the pattern steps through four modes, from always ready
  // to heavy stalling. A requested hold-off overrides the pattern.
  always @(posedge clk_i) begin
    if (hold_off_reqs != hold_off_seen) begin
      hold_off_seen <= hold_off_reqs;
      hold_off_cycles <= HOLD_OFF_LEN - 1;
      out_ready_i <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      case ((cycle_count / 64) % 4)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 3) != 0);
        2:       out_ready_i <= ($urandom_range(0, 9) < 3);
        default: out_ready_i <= ((cycle_count % 16) < 11);
      endcase
    end
  end

  function automatic bit is_leap(int unsigned y);
    return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    return lens[m - 1] + ((m == 2 && is_leap(y)) ? 1 : 0);
  endfunction

  // Serial count of 1 January of year y.
  function automatic int unsigned jan1_serial(int unsigned y);
    int unsigned p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic date_result_t calendar_convert(cmd_e cmd, int unsigned d,
      int unsigned m, int unsigned y, int unsigned cnt);
    date_result_t res;
    int unsigned serial, doy, rem, n400, n100, n4, n1;
    res = '0;
    if (cmd == CMD_TO_SERIAL) begin
      if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1 || d > month_days(m, y)) begin
        res.invalid = 1'b1;
        return res;
      end
      doy = 0;
      for (int k = 1; k < m; k++) doy += month_days(k, y);
      doy += d - 1;
      serial = jan1_serial(y) + doy;
    end else begin
      if (cnt > LAST_COUNT) begin
        res.invalid = 1'b1;
        return res;
      end
      n400 = cnt / 146097;
      rem = cnt % 146097;
      n100 = rem / 36524;
      if (n100 > 3) n100 = 3;
      rem -= n100 * 36524;
      n4 = rem / 1461;
      rem %= 1461;
      n1 = rem / 365;
      if (n1 > 3) n1 = 3;
      rem -= n1 * 365;
      y = 400 * n400 + 100 * n100 + 4 * n4 + n1 + 1;
      doy = rem;
      serial = cnt;
      // Walk the months to split day of year.
      m = 1;
      while (m < 12 && rem >= month_days(m, y)) begin
        rem -= month_days(m, y);
        m++;
      end
      d = rem + 1;
    end
    res.serial_days = 22'(serial);
    res.day = 5'(d);
    res.month = 4'(m);
    res.year = 14'(y);
    res.weekday = 3'(serial % 7);
    res.week = 6'((doy + jan1_serial(y) % 7) / 7 + 1);
    return res;
  endfunction

  // Offer one item, idling in random bursts; return once the transfer happens.
  task automatic send_item(cmd_e cmd, logic [4:0] d, logic [3:0] m, logic [13:0] y,
      logic [21:0] cnt, bit no_gaps = 0);
    int unsigned gap;
    if (burst_left == 0 && !no_gaps) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    day_i       <= d;
    month_i     <= m;
    year_i      <= y;
    day_count_i <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(calendar_convert(cmd, d, m, y, cnt));
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    date_result_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{serial_days_o, out_day_o, out_month_o, out_year_o, weekday_o,
              week_of_year_o, invalid_o};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic send_date(int unsigned d, int unsigned m, int unsigned y);
    send_item(CMD_TO_SERIAL, d, m, y, $urandom_range(0, 22'h3fffff));
  endtask

  task automatic send_count(int unsigned cnt);
    send_item(CMD_TO_DATE, $urandom, $urandom, $urandom, cnt);
  endtask

  task automatic send_random_date();
    int unsigned y, m;
    y = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) * 400 - $urandom_range(0, 1)
                                    : $urandom_range(1, 9999);
    m = $urandom_range(1, 12);
    send_date($urandom_range(1, month_days(m, y)), m, y);
  endtask

  // Field extremes, calendar edges and every invalid case.
  task automatic test_directed();
    send_date(1, 1, 1);
    send_date(31, 12, 9999);
    send_date(29, 2, 2000);   // leap by the 400 rule
    send_date(29, 2, 1900);   // century, not leap
    send_date(29, 2, 2004);
    send_date(31, 12, 2000);
    send_date(0, 5, 2020);    // day zero
    send_date(31, 4, 2020);   // past end of month
    send_date(31, 15, 9999);
    send_date(1, 0, 100);     // month zero
    send_date(1, 13, 100);
    send_date(1, 1, 0);       // year zero
    send_date(1, 1, 10000);
    send_date(31, 15, 16383);
    send_count(0);
    send_count(LAST_COUNT);
    send_count(LAST_COUNT + 1);
    send_count(22'h3fffff);
    send_count(146096);       // last day of a 400-year cycle
    send_count(1460);         // last day of a leap year in a 4-year block
    send_count(36524);
    send_count(146097);
  endtask

  // Mostly well-formed dates and counts, with raw noise mixed in.
  task automatic test_random_mix(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       send_item(cmd_e'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                           $urandom);
        1, 2, 3: send_count($urandom_range(0, LAST_COUNT));
        default: send_random_date();
      endcase
    end
  endtask

  // Hold the output off for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_off_reqs = hold_off_reqs + 1;
    for (int unsigned i = 0; i < 200; i++) begin
      if (i % 2 == 0) send_random_date();
      else send_item(CMD_TO_DATE, 0, 0, 0, $urandom_range(0, LAST_COUNT), 1);
    end
  endtask

  // Counts at year boundaries, where the month walk and cycle clamps act.
  task automatic test_year_boundaries(int unsigned n);
    int unsigned y, cnt;
    for (int unsigned i = 0; i < n; i++) begin
      y = $urandom_range(1, 9999);
      cnt = jan1_serial(y) + $urandom_range(0, 1) - 1;
      if (y == 1) cnt = 0;
      send_count(cnt);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix(1000);
    test_backpressure();
    test_year_boundaries(400);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
